### design/programmable_interval_timer_assert.svh
// Assertion macros shared by the timer's checker.
// No dependencies; pulled in by `include.
`ifndef PROGRAMMABLE_INTERVAL_TIMER_ASSERT_SVH
`define PROGRAMMABLE_INTERVAL_TIMER_ASSERT_SVH

// Clocked assertion, masked while reset is asserted.
`define PIT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/pit_pkg.sv
// Types, codes and per-channel helper functions for the interval timer.
// No dependencies; imported by pit_channel and programmable_interval_timer.
package pit_pkg;

    localparam int NUM_CHANNELS = 3;

    localparam logic [16:0] FULL_COUNT = 17'h10000;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    localparam logic [1:0] ADDR_CTRL    = 2'd3;
    localparam logic [1:0] SEL_READBACK = 2'd3;
    localparam logic [1:0] ACC_LATCH    = 2'd0;

    // counting modes
    localparam logic [2:0] MODE_INT_ON_TC = 3'd0;
    localparam logic [2:0] MODE_ONE_SHOT  = 3'd1;
    localparam logic [2:0] MODE_RATE      = 3'd2;
    localparam logic [2:0] MODE_SQUARE    = 3'd3;
    localparam logic [2:0] MODE_RESET     = 3'd3;

    // byte sequencing for data port reads and writes
    localparam logic [2:0] PH_HIGH    = 3'd2;
    localparam logic [2:0] PH_WORD_LO = 3'd3;
    localparam logic [2:0] PH_WORD_HI = 3'd4;

    // latched count sequencing
    localparam logic [1:0] LP_NONE = 2'd0;
    localparam logic [1:0] LP_HIGH = 2'd2;
    localparam logic [1:0] LP_WORD = 2'd3;

    // terminal count stage
    localparam logic [1:0] TS_BEFORE = 2'd0;
    localparam logic [1:0] TS_AT     = 2'd1;
    localparam logic [1:0] TS_PAST   = 2'd2;

    typedef struct packed {
        logic tick;     // PIT clock beat
        logic wr;       // data port write
        logic prog;     // control word programs this channel
        logic latch;    // counter latch
        logic stat;     // read-back status latch
        logic rd;       // data port read
    } cmd_t;

    // modes 6 and 7 alias to 2 and 3
    function automatic logic [2:0] eff_mode(input logic [2:0] mode);
        return (mode >= 3'd6) ? mode - 3'd4 : mode;
    endfunction

    function automatic logic out_level(input logic [2:0] mode, input logic [16:0] n,
                                       input logic [1:0] stage, input logic [16:0] phase,
                                       input logic ticked);
        logic [17:0] half;
        logic        lvl;
        half = ({1'b0, n} + 18'd1) >> 1;
        case (eff_mode(mode))
            MODE_INT_ON_TC: lvl = (stage != TS_BEFORE);
            MODE_ONE_SHOT:  lvl = (stage == TS_BEFORE);
            MODE_RATE:      lvl = (phase == 17'd0) && ticked;
            MODE_SQUARE:    lvl = ({1'b0, phase} < half);
            default:        lvl = (stage == TS_AT);
        endcase
        return lvl;
    endfunction

    // phase < n, so twice the phase needs at most one subtract to wrap
    function automatic logic [15:0] live_count(input logic [2:0] mode, input logic [16:0] n,
                                               input logic [15:0] elapsed,
                                               input logic [16:0] phase);
        logic [17:0] dbl;
        logic [16:0] diff;
        dbl = {phase, 1'b0};
        if (dbl >= {1'b0, n}) begin
            dbl = dbl - {1'b0, n};
        end
        case (eff_mode(mode))
            MODE_RATE:   diff = n - phase;
            MODE_SQUARE: diff = n - dbl[16:0];
            default:     diff = n - {1'b0, elapsed};
        endcase
        return diff[15:0];
    endfunction

endpackage

### design/pit_channel.sv
// One timer channel: programming, load, latch, read sequencing and tick phase.
// Depends on pit_pkg.
module pit_channel (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  pit_pkg::cmd_t  cmd,
    input  logic [7:0]     wdata,
    output logic [7:0]     rdata,
    output logic           out_lvl
);
    import pit_pkg::*;

    logic [2:0]  mode_reg,      mode_next;
    logic [16:0] count_reg,     count_next;
    logic        bcd_reg,       bcd_next;
    logic [1:0]  acc_reg,       acc_next;
    logic [2:0]  rphase_reg,    rphase_next;
    logic [2:0]  wphase_reg,    wphase_next;
    logic [7:0]  wlow_reg,      wlow_next;
    logic [15:0] latched_reg,   latched_next;
    logic [1:0]  lphase_reg,    lphase_next;
    logic [7:0]  status_reg,    status_next;
    logic        held_reg,      held_next;
    logic [15:0] elapsed_reg,   elapsed_next;
    logic [16:0] phase_reg,     phase_next;
    logic [1:0]  stage_reg,     stage_next;
    logic        ticked_reg,    ticked_next;

    logic [15:0] live;
    logic [16:0] phase_inc;
    logic        load;
    logic [15:0] load_val;

    assign live      = live_count(mode_reg, count_reg, elapsed_reg, phase_reg);
    assign phase_inc = phase_reg + 17'd1;

    always_comb begin
        mode_next    = mode_reg;
        count_next   = count_reg;
        bcd_next     = bcd_reg;
        acc_next     = acc_reg;
        rphase_next  = rphase_reg;
        wphase_next  = wphase_reg;
        wlow_next    = wlow_reg;
        latched_next = latched_reg;
        lphase_next  = lphase_reg;
        status_next  = status_reg;
        held_next    = held_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        ticked_next  = ticked_reg;
        rdata        = 8'h00;
        load         = 1'b0;
        load_val     = {8'h00, wdata};

        if (en && cmd.tick) begin
            if (stage_reg == TS_BEFORE) begin
                if ({1'b0, elapsed_reg} + 17'd1 == count_reg) begin
                    stage_next = TS_AT;
                end
            end else begin
                stage_next = TS_PAST;
            end
            elapsed_next = elapsed_reg + 16'd1;
            phase_next   = (phase_inc >= count_reg) ? 17'd0 : phase_inc;
            ticked_next  = 1'b1;
        end

        if (en && cmd.wr) begin
            case (wphase_reg)
                PH_HIGH: begin
                    load     = 1'b1;
                    load_val = {wdata, 8'h00};
                end
                PH_WORD_LO: begin
                    wlow_next   = wdata;
                    wphase_next = PH_WORD_HI;
                end
                PH_WORD_HI: begin
                    load        = 1'b1;
                    load_val    = {wdata, wlow_reg};
                    wphase_next = PH_WORD_LO;
                end
                default: begin
                    load = 1'b1;
                end
            endcase
        end

        if (load) begin
            count_next   = (load_val == 16'h0000) ? FULL_COUNT : {1'b0, load_val};
            elapsed_next = 16'h0000;
            phase_next   = 17'd0;
            stage_next   = TS_BEFORE;
            ticked_next  = 1'b0;
        end

        if (en && cmd.prog) begin
            acc_next    = wdata[5:4];
            rphase_next = {1'b0, wdata[5:4]};
            wphase_next = {1'b0, wdata[5:4]};
            mode_next   = wdata[3:1];
            bcd_next    = wdata[0];
        end

        // access mode 0 captures but leaves nothing marked
        if (en && cmd.latch && lphase_reg == LP_NONE) begin
            latched_next = live;
            lphase_next  = acc_reg;
        end

        if (en && cmd.stat && !held_reg) begin
            status_next = {out_level(mode_reg, count_reg, stage_reg, phase_reg, ticked_reg),
                           1'b0, acc_reg, mode_reg, bcd_reg};
            held_next   = 1'b1;
        end

        if (en && cmd.rd) begin
            if (held_reg) begin
                held_next = 1'b0;
                rdata     = status_reg;
            end else if (lphase_reg != LP_NONE) begin
                case (lphase_reg)
                    LP_HIGH: begin
                        rdata       = latched_reg[15:8];
                        lphase_next = LP_NONE;
                    end
                    LP_WORD: begin
                        rdata       = latched_reg[7:0];
                        lphase_next = LP_HIGH;
                    end
                    default: begin
                        rdata       = latched_reg[7:0];
                        lphase_next = LP_NONE;
                    end
                endcase
            end else begin
                case (rphase_reg)
                    PH_HIGH: rdata = live[15:8];
                    PH_WORD_LO: begin
                        rdata       = live[7:0];
                        rphase_next = PH_WORD_HI;
                    end
                    PH_WORD_HI: begin
                        rdata       = live[15:8];
                        rphase_next = PH_WORD_LO;
                    end
                    default: rdata = live[7:0];
                endcase
            end
        end
    end

    // OUT as it stands once this beat has been applied
    assign out_lvl = out_level(mode_next, count_next, stage_next, phase_next, ticked_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_RESET;
            count_reg   <= FULL_COUNT;
            bcd_reg     <= 1'b0;
            acc_reg     <= 2'd0;
            rphase_reg  <= 3'd0;
            wphase_reg  <= 3'd0;
            wlow_reg    <= 8'h00;
            latched_reg <= 16'h0000;
            lphase_reg  <= LP_NONE;
            status_reg  <= 8'h00;
            held_reg    <= 1'b0;
            elapsed_reg <= 16'h0000;
            phase_reg   <= 17'd0;
            stage_reg   <= TS_BEFORE;
            ticked_reg  <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            bcd_reg     <= bcd_next;
            acc_reg     <= acc_next;
            rphase_reg  <= rphase_next;
            wphase_reg  <= wphase_next;
            wlow_reg    <= wlow_next;
            latched_reg <= latched_next;
            lphase_reg  <= lphase_next;
            status_reg  <= status_next;
            held_reg    <= held_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            ticked_reg  <= ticked_next;
        end
    end

endmodule

### design/programmable_interval_timer.sv
// Three-channel interval timer, top level.
// Depends on pit_pkg and pit_channel.
//
// Usage:
//   Each input beat on s_* is one PIT clock tick (s_func 0), a byte write
//   (s_func 1) or a byte read (s_func 2) at port s_addr: ports 0-2 are the
//   channel data ports, port 3 takes control words (program, counter latch,
//   read-back). Every input beat yields exactly one result beat on m_*:
//   m_rdata carries the byte read (0 otherwise) and m_out0..m_out2 the OUT
//   levels of the channels once the beat has taken effect.
//   From input acceptance to m_valid a beat passes the input register, which
//   the accepting edge loads, and then the result register, which takes the
//   channel update once it can advance.
//   Throughput is one beat per cycle while m_ready is high; every channel's
//   update is a single pass of its own compare/subtract logic, so nothing
//   iterates. When m_ready is low the result register holds and the input
//   register still takes one more beat; s_ready falls only when both are full.
//   Reset (aresetn low, synchronous) empties both registers and returns all
//   channels to mode 3, count 65536, nothing latched.
module programmable_interval_timer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [1:0] s_addr,
    input  logic [7:0] s_wdata,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_rdata,
    output logic       m_out0,
    output logic       m_out1,
    output logic       m_out2
);
    import pit_pkg::*;

    logic       in_valid_reg;
    logic [1:0] func_reg;
    logic [1:0] addr_reg;
    logic [7:0] wdata_reg;

    logic       out_valid_reg;
    logic [7:0] rdata_reg,  rdata_next;
    logic       out0_reg;
    logic       out1_reg;
    logic       out2_reg;

    logic       advance;
    logic       proc;
    logic       is_ctrl;
    logic [1:0] sel;
    logic [1:0] acc;

    cmd_t       ch_cmd   [NUM_CHANNELS];
    logic [7:0] ch_rdata [NUM_CHANNELS];
    logic       ch_out   [NUM_CHANNELS];

    assign advance = !out_valid_reg || m_ready;
    assign proc    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign is_ctrl = (func_reg == FUNC_WRITE) && (addr_reg == ADDR_CTRL);
    assign sel     = wdata_reg[7:6];
    assign acc     = wdata_reg[5:4];

    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
        logic picked;
        logic rb_sel;

        assign picked = (sel == 2'(c));
        assign rb_sel = (sel == SEL_READBACK) && wdata_reg[c + 1];

        assign ch_cmd[c].tick  = (func_reg == FUNC_TICK);
        assign ch_cmd[c].wr    = (func_reg == FUNC_WRITE) && (addr_reg == 2'(c));
        assign ch_cmd[c].prog  = is_ctrl && picked && (acc != ACC_LATCH);
        assign ch_cmd[c].latch = is_ctrl && ((picked && acc == ACC_LATCH) ||
                                             (rb_sel && !wdata_reg[5]));
        assign ch_cmd[c].stat  = is_ctrl && rb_sel && !wdata_reg[4];
        assign ch_cmd[c].rd    = (func_reg == FUNC_READ) && (addr_reg == 2'(c));

        pit_channel u_ch (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (proc),
            .cmd     (ch_cmd[c]),
            .wdata   (wdata_reg),
            .rdata   (ch_rdata[c]),
            .out_lvl (ch_out[c])
        );
    end

    // only the addressed channel drives a non-zero byte
    always_comb begin
        rdata_next = 8'h00;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            rdata_next = rdata_next | ch_rdata[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= s_func;
            addr_reg  <= s_addr;
            wdata_reg <= s_wdata;
        end
        if (proc) begin
            rdata_reg <= rdata_next;
            out0_reg  <= ch_out[0];
            out1_reg  <= ch_out[1];
            out2_reg  <= ch_out[2];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_rdata = rdata_reg;
    assign m_out0  = out0_reg;
    assign m_out1  = out1_reg;
    assign m_out2  = out2_reg;

endmodule

### design/pit_checker.sv
// Port-level checker for the interval timer, bound to the top level.
// Depends on programmable_interval_timer_assert.svh.
`include "programmable_interval_timer_assert.svh"

module pit_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_rdata,
    input logic       m_out0,
    input logic       m_out1,
    input logic       m_out2
);

    // a stalled result beat stays offered
    `PIT_ASSERT(a_m_valid_held, aclk, aresetn, m_valid && !m_ready |=> m_valid, "m_valid dropped")

    // and keeps its payload
    `PIT_ASSERT(a_m_payload_held, aclk, aresetn, m_valid && !m_ready |=> $stable(m_rdata) && $stable(m_out0) && $stable(m_out1) && $stable(m_out2), "result changed in stall")

    // input back-pressure only comes from a stalled result
    `PIT_ASSERT(a_ready_cause, aclk, aresetn, !s_ready |-> m_valid && !m_ready, "s_ready low without stall")

    // nothing is offered straight after reset
    `PIT_ASSERT_ALWAYS(a_reset_empty, aclk, $past(!aresetn) |-> !m_valid, "m_valid after reset")

endmodule

bind programmable_interval_timer pit_checker u_pit_checker (.*);
